// ----- rtl/rth_pkg.sv -----
// Package for the 8-bit integer RGB to HSV converter.
// Word types, hue sector codes, constants and the one-bit divider step.
// Depends on nothing; used by every module under rtl.
`default_nettype none

package rth_pkg;

  // Number of divider cells: one quotient bit per cell, 8-bit quotients
  localparam int RthSteps = 8;

  // Scale and sector constants
  localparam logic [15:0] RthSatScale = 16'd255;
  localparam logic [15:0] RthHueScale = 16'd60;
  localparam logic [8:0]  RthHueGreen = 9'd120;
  localparam logic [8:0]  RthHueBlue  = 9'd240;
  localparam logic [8:0]  RthHueWrap  = 9'd360;

  // Input word
  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } rth_in_t;

  // Output word
  typedef struct packed {
    logic [8:0] hue_out;
    logic [7:0] sat_out;
    logic [7:0] val_out;
  } rth_out_t;

  // Which channel is largest (red wins ties over green, green over blue)
  typedef enum logic [1:0] {
    RthSecRed,
    RthSecGreen,
    RthSecBlue
  } rth_sector_e;

  // One restoring-division lane: partial remainder, dividend bits still to
  // shift in, divisor and quotient bits gathered so far
  typedef struct packed {
    logic [7:0] rem;
    logic [7:0] low;
    logic [7:0] dvs;
    logic [7:0] quo;
  } rth_lane_t;

  // Everything that travels down the cell chain
  typedef struct packed {
    rth_lane_t   sat;
    rth_lane_t   hue;
    logic        neg;
    rth_sector_e sector;
    logic        grey;
    logic [7:0]  val;
  } rth_work_t;

  // One quotient bit: shift in the next dividend bit, subtract if it fits.
  // The remainder stays below the divisor, so 8 bits hold it.
  function automatic rth_lane_t rth_div_step(input rth_lane_t lane);
    rth_lane_t  res;
    logic [8:0] trial;
    logic [8:0] diff;
    logic       fits;
    trial = {lane.rem, lane.low[7]};
    diff  = trial - {1'b0, lane.dvs};
    fits  = (trial >= {1'b0, lane.dvs});
    res.rem = fits ? diff[7:0] : trial[7:0];
    res.low = {lane.low[6:0], 1'b0};
    res.dvs = lane.dvs;
    res.quo = {lane.quo[6:0], fits};
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/rth_front.sv -----
// Front stage of the RGB to HSV converter: max, min, delta, sector and
// the dividends for both divider lanes. Depends on rth_pkg.
`default_nettype none

module rth_front import rth_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      valid_i,
  output logic           ready_o,
  input  wire rth_in_t   word_i,
  output logic           valid_o,
  input  wire logic      ready_i,
  output rth_work_t      work_o
);

  logic        valid_q;
  rth_work_t   work_q;
  rth_work_t   work_d;

  logic        red_top;
  logic        green_top;
  logic [7:0]  max_ch;
  logic [7:0]  min_ch;
  logic [7:0]  delta;
  logic [7:0]  pos_ch;
  logic [7:0]  sub_ch;
  logic [7:0]  abs_diff;
  logic [15:0] sat_num;
  logic [15:0] hue_num;

  // Largest channel with red, then green, winning ties
  always_comb begin
    red_top   = (word_i.red_in >= word_i.green_in) && (word_i.red_in >= word_i.blue_in);
    green_top = !red_top && (word_i.green_in >= word_i.blue_in);
    if (red_top) begin
      max_ch = word_i.red_in;
      pos_ch = word_i.green_in;
      sub_ch = word_i.blue_in;
    end else if (green_top) begin
      max_ch = word_i.green_in;
      pos_ch = word_i.blue_in;
      sub_ch = word_i.red_in;
    end else begin
      max_ch = word_i.blue_in;
      pos_ch = word_i.red_in;
      sub_ch = word_i.green_in;
    end
    min_ch = word_i.red_in;
    if (word_i.green_in < min_ch) min_ch = word_i.green_in;
    if (word_i.blue_in < min_ch)  min_ch = word_i.blue_in;
  end

  // Delta, magnitude of the hue difference and the two dividends
  always_comb begin
    delta    = max_ch - min_ch;
    abs_diff = (pos_ch >= sub_ch) ? (pos_ch - sub_ch) : (sub_ch - pos_ch);
    sat_num  = 16'(delta) * RthSatScale;
    hue_num  = 16'(abs_diff) * RthHueScale;
  end

  // Both quotients stay below 256, so the top dividend byte starts as
  // the partial remainder
  always_comb begin
    work_d.sat.rem = sat_num[15:8];
    work_d.sat.low = sat_num[7:0];
    work_d.sat.dvs = max_ch;
    work_d.sat.quo = '0;
    work_d.hue.rem = hue_num[15:8];
    work_d.hue.low = hue_num[7:0];
    work_d.hue.dvs = delta;
    work_d.hue.quo = '0;
    work_d.neg     = (pos_ch < sub_ch);
    work_d.sector  = red_top ? RthSecRed : (green_top ? RthSecGreen : RthSecBlue);
    work_d.grey    = (delta == 8'd0);
    work_d.val     = max_ch;
  end

  // Stage register; takes a word whenever it is empty or draining
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      work_q <= work_d;
    end
  end

  assign valid_o = valid_q;
  assign work_o  = work_q;

endmodule

`default_nettype wire

// ----- rtl/rth_div_cell.sv -----
// One cell of the divider chain: a quotient bit for the saturation lane
// and one for the hue lane, then hands the word on. Depends on rth_pkg.
`default_nettype none

module rth_div_cell import rth_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      valid_i,
  output logic           ready_o,
  input  wire rth_work_t work_i,
  output logic           valid_o,
  input  wire logic      ready_i,
  output rth_work_t      work_o
);

  logic      valid_q;
  rth_work_t work_q;
  rth_work_t work_d;

  // One restoring step on each lane, side data passes through
  always_comb begin
    work_d     = work_i;
    work_d.sat = rth_div_step(work_i.sat);
    work_d.hue = rth_div_step(work_i.hue);
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      work_q <= work_d;
    end
  end

  assign valid_o = valid_q;
  assign work_o  = work_q;

endmodule

`default_nettype wire

// ----- rtl/rth_back.sv -----
// Back stage of the RGB to HSV converter: sector base plus signed hue
// offset, grey handling, output register. Depends on rth_pkg.
`default_nettype none

module rth_back import rth_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      valid_i,
  output logic           ready_o,
  input  wire rth_work_t work_i,
  output logic           valid_o,
  input  wire logic      ready_i,
  output rth_out_t       word_o
);

  logic       valid_q;
  rth_out_t   word_q;
  rth_out_t   word_d;
  logic [8:0] offs;
  logic       neg;

  // Offset is at most 60; a zero offset is never negative
  always_comb begin
    offs = {1'b0, work_i.hue.quo};
    neg  = work_i.neg && (work_i.hue.quo != 8'd0);
    word_d.val_out = work_i.val;
    word_d.sat_out = work_i.sat.quo;
    unique case (work_i.sector)
      RthSecRed:   word_d.hue_out = neg ? (RthHueWrap - offs) : offs;
      RthSecGreen: word_d.hue_out = neg ? (RthHueGreen - offs) : (RthHueGreen + offs);
      RthSecBlue:  word_d.hue_out = neg ? (RthHueBlue - offs) : (RthHueBlue + offs);
      default:     word_d.hue_out = '0;
    endcase
    if (work_i.grey) begin
      word_d.hue_out = '0;
      word_d.sat_out = '0;
    end
  end

  // Output register
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

`default_nettype wire

// ----- rtl/rgb_to_hsv_integer.sv -----
// RGB to HSV converter, 8-bit integer channels in, hue 0..359 out.
// An accepted input word passes through the front stage, then 8 divider
// cells at one quotient bit each, then the output stage.
// Throughput: one word per cycle while out_stall_i is low; every stage refills while it drains.
// Reset: rst_ni clears all stage valid bits at once; no clearing pass.
// Depends on rth_pkg, rth_front, rth_div_cell and rth_back.
`default_nettype none

module rgb_to_hsv_integer import rth_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire rth_in_t in_data_i,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output rth_out_t     out_data_o
);

  logic [RthSteps:0] chain_valid;
  logic [RthSteps:0] chain_ready;
  rth_work_t         chain_work [RthSteps+1];
  logic              front_ready;

  // Front stage
  rth_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (front_ready),
    .word_i  (in_data_i),
    .valid_o (chain_valid[0]),
    .ready_i (chain_ready[0]),
    .work_o  (chain_work[0])
  );

  assign in_stall_o = !front_ready;

  // Divider chain
  for (genvar k = 0; k < RthSteps; k++) begin : g_cell
    rth_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_valid[k]),
      .ready_o (chain_ready[k]),
      .work_i  (chain_work[k]),
      .valid_o (chain_valid[k+1]),
      .ready_i (chain_ready[k+1]),
      .work_o  (chain_work[k+1])
    );
  end

  // Output stage
  rth_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (chain_valid[RthSteps]),
    .ready_o (chain_ready[RthSteps]),
    .work_i  (chain_work[RthSteps]),
    .valid_o (out_valid_o),
    .ready_i (!out_stall_i),
    .word_o  (out_data_o)
  );

  // Hue never wraps to 360 or beyond
  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.hue_out < RthHueWrap))
    else $error("hue out of range");

  // Zero saturation only for a grey pixel, which has zero hue
  a_grey_hue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.sat_out == 8'd0)) |-> (out_data_o.hue_out == 9'd0))
    else $error("nonzero hue with zero saturation");

  // An accepted word is held in the front stage next cycle
  a_front_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> chain_valid[0])
    else $error("accepted word lost at front stage");

  // A free-running output never backs up the chain
  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output drains");

endmodule

`default_nettype wire

// ----- tb/tb_rgb_to_hsv_integer.sv -----
// Testbench for rgb_to_hsv_integer: drives RGB pixel words, predicts HSV words
// and checks every output word in order, under several idle and stall mixes.
// Depends on rth_pkg and the rgb_to_hsv_integer RTL.
`timescale 1ns / 100ps

module tb_rgb_to_hsv_integer;
  import rth_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int DrainWait  = 14;
  localparam int RandItems  = 225;
  localparam int MaxShown   = 10;

  // HSV arithmetic constants
  localparam int SatFull   = 255;
  localparam int HueStep   = 60;
  localparam int HueGreen  = 120;
  localparam int HueBlue   = 240;
  localparam int HueCircle = 360;

  typedef enum int {
    IdleNone,
    IdleSend,
    IdleRecv,
    IdleBoth
  } idle_mode_e;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  rth_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  rth_out_t out_data_o;

  rth_in_t    pixel_q[$];
  rth_out_t   hsv_q[$];
  idle_mode_e idle_mode = IdleNone;
  logic       in_took = 1'b0;
  int         mismatches = 0;
  int         cycles = 0;
  rth_in_t    next_px;

  rgb_to_hsv_integer u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Expected HSV word for one pixel
  function automatic rth_out_t hsv_of(rth_in_t px);
    rth_out_t    res;
    rth_sector_e sec;
    int          r, g, b, mx, mn, dl, hue, sat;
    r = int'(px.red_in);
    g = int'(px.green_in);
    b = int'(px.blue_in);
    mx = (r > g) ? r : g;
    mx = (mx > b) ? mx : b;
    mn = (r < g) ? r : g;
    mn = (mn < b) ? mn : b;
    dl = mx - mn;
    hue = 0;
    sat = 0;
    if (dl != 0) begin
      sat = (SatFull * dl) / mx;
      // first largest channel in red, green, blue order picks the sector
      if (r == mx) sec = RthSecRed;
      else if (g == mx) sec = RthSecGreen;
      else sec = RthSecBlue;
      case (sec)
        RthSecRed:   hue = (HueStep * (g - b)) / dl;
        RthSecGreen: hue = HueGreen + (HueStep * (b - r)) / dl;
        default:     hue = HueBlue + (HueStep * (r - g)) / dl;
      endcase
      if (hue < 0) hue += HueCircle;
    end
    res.hue_out = hue[8:0];
    res.sat_out = sat[7:0];
    res.val_out = mx[7:0];
    return res;
  endfunction

  // Random pixel, biased toward greys, ties and channel extremes
  function automatic rth_in_t rand_pixel();
    rth_in_t px;
    int      kind;
    logic [7:0] v;
    kind = $urandom_range(0, 9);
    px = rth_in_t'($urandom);
    v = 8'($urandom);
    case (kind)
      0: px = '{red_in: v, green_in: v, blue_in: v};
      1: begin
        case ($urandom_range(0, 2))
          0: px.green_in = px.red_in;
          1: px.blue_in = px.green_in;
          default: px.blue_in = px.red_in;
        endcase
      end
      2: begin
        px.red_in   = ($urandom_range(0, 2) == 0) ? 8'hff : px.red_in;
        px.green_in = ($urandom_range(0, 2) == 0) ? 8'h00 : px.green_in;
        px.blue_in  = ($urandom_range(0, 2) == 0) ? 8'hff : px.blue_in;
      end
      3: begin
        // one channel dominant by a small delta
        px.green_in = px.red_in - 8'($urandom_range(0, 3));
        px.blue_in  = px.red_in - 8'($urandom_range(0, 3));
      end
      default: ;
    endcase
    return px;
  endfunction

  function automatic rth_in_t rgb(int r, int g, int b);
    rth_in_t px;
    px.red_in   = r[7:0];
    px.green_in = g[7:0];
    px.blue_in  = b[7:0];
    return px;
  endfunction

  task automatic note_mismatch(string what);
    if (mismatches < MaxShown) $display("%0d: %s", cycles, what);
    mismatches++;
  endtask

  // Input side: hold the word until taken, then maybe leave a gap
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_took) begin
        if (pixel_q.size() != 0 &&
            !((idle_mode == IdleSend && $urandom_range(0, 99) < 49) ||
              (idle_mode == IdleBoth && $urandom_range(0, 99) < 19))) begin
          next_px = pixel_q.pop_front();
          in_valid_i <= 1'b1;
          in_data_i  <= next_px;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= (idle_mode == IdleRecv && $urandom_range(0, 99) < 49) ||
                     (idle_mode == IdleBoth && $urandom_range(0, 99) < 19);
    end
  end

  // Output checking, input word bookkeeping and the cycle limit
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
        $display("Mismatches found");
        $finish;
      end
      if (out_valid_o && !out_stall_i) begin
        if (hsv_q.size() == 0) begin
          note_mismatch($sformatf("unexpected word hue=%0d sat=%0d val=%0d",
                                  out_data_o.hue_out, out_data_o.sat_out,
                                  out_data_o.val_out));
        end else begin
          rth_out_t want;
          want = hsv_q.pop_front();
          if (out_data_o.hue_out !== want.hue_out)
            note_mismatch($sformatf("hue exp %0d got %0d", want.hue_out,
                                    out_data_o.hue_out));
          if (out_data_o.sat_out !== want.sat_out)
            note_mismatch($sformatf("sat exp %0d got %0d", want.sat_out,
                                    out_data_o.sat_out));
          if (out_data_o.val_out !== want.val_out)
            note_mismatch($sformatf("val exp %0d got %0d", want.val_out,
                                    out_data_o.val_out));
        end
      end
      if (in_valid_i && !in_stall_o) hsv_q.push_back(hsv_of(in_data_i));
      in_took <= in_valid_i && !in_stall_o;
    end
  end

  // Stimulus: directed pixels, then random pixels in each idle mix
  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // black, white, greys
    pixel_q.push_back(rgb(0, 0, 0));
    pixel_q.push_back(rgb(255, 255, 255));
    pixel_q.push_back(rgb(128, 128, 128));
    pixel_q.push_back(rgb(1, 1, 1));
    // pure primaries and smallest nonzero
    pixel_q.push_back(rgb(255, 0, 0));
    pixel_q.push_back(rgb(0, 255, 0));
    pixel_q.push_back(rgb(0, 0, 255));
    pixel_q.push_back(rgb(1, 0, 0));
    pixel_q.push_back(rgb(0, 1, 0));
    pixel_q.push_back(rgb(0, 0, 1));
    // ties for the largest channel
    pixel_q.push_back(rgb(255, 255, 0));
    pixel_q.push_back(rgb(255, 0, 255));
    pixel_q.push_back(rgb(0, 255, 255));
    pixel_q.push_back(rgb(200, 100, 200));
    // red sector wrap, and a negative fraction that truncates to zero
    pixel_q.push_back(rgb(255, 0, 10));
    pixel_q.push_back(rgb(255, 0, 1));
    pixel_q.push_back(rgb(255, 254, 255));
    pixel_q.push_back(rgb(254, 255, 255));
    pixel_q.push_back(rgb(255, 0, 254));
    // alternating bit patterns
    pixel_q.push_back(rgb('haa, 'h55, 'hcc));
    pixel_q.push_back(rgb('h55, 'haa, 'h33));
    pixel_q.push_back(rgb('h33, 'hcc, 'haa));

    for (int m = 0; m < 4; m++) begin
      idle_mode = idle_mode_e'(m);
      for (int i = 0; i < RandItems; i++) pixel_q.push_back(rand_pixel());
      while (pixel_q.size() != 0) @(posedge clk_i);
    end

    while (in_valid_i) @(posedge clk_i);
    while (hsv_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
